// File: design/lbrp_pkg.sv
// ----------------------------------------------------------------------------
// lbrp_pkg
// Types, codes and constants shared by the log block record packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbrp_pkg;

    localparam int RECORD_HEADER_BYTES = 4;

    localparam logic [15:0] MAX_DELTA = 16'hffff;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_FLUSH   = 2'd1;
    localparam logic [1:0] OP_WRITTEN = 2'd2;

    localparam logic [2:0] KIND_STORED    = 3'd0;
    localparam logic [2:0] KIND_SEALED    = 3'd1;
    localparam logic [2:0] KIND_BUSY      = 3'd2;
    localparam logic [2:0] KIND_TOO_LARGE = 3'd3;
    localparam logic [2:0] KIND_NOTHING   = 3'd4;
    localparam logic [2:0] KIND_WRITE_ACK = 3'd5;

    localparam logic [1:0] REG_BLOCK_PAYLOAD_BYTES = 2'd0;
    localparam logic [1:0] REG_RING_BLOCK_COUNT    = 2'd1;
    localparam logic [1:0] REG_START_GENERATION    = 2'd2;
    localparam logic [1:0] REG_START_BLOCK         = 2'd3;

    localparam logic [11:0] RESET_BLOCK_PAYLOAD_BYTES = 12'd4080;
    localparam logic [15:0] RESET_RING_BLOCK_COUNT    = 16'd1024;
    localparam logic [31:0] RESET_START_GENERATION    = 32'd1;
    localparam logic [15:0] RESET_START_BLOCK         = 16'd0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] now_ms;
        logic [7:0]  record_type;
        logic [7:0]  record_size;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] record_offset;
        logic [15:0] time_delta;
        logic        opened_block;
        logic [47:0] block_time;
        logic [31:0] header_generation;
        logic [7:0]  echo_type;
        logic [15:0] write_index;
        logic [11:0] sealed_bytes;
        logic        ring_wrapped;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    valid;
        logic    two;
        t_result first;
        t_result second;
    } t_batch;

    typedef struct packed {
        logic [11:0] block_payload_bytes;
        logic [15:0] ring_block_count;
        logic        load_generation;
        logic        load_block;
        logic [31:0] load_value;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/lbrp_if.sv
// ----------------------------------------------------------------------------
// lbrp_if
// Valid/ready channels of the log block record packer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbrp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [47:0] now_ms;
    logic [7:0]  record_type;
    logic [7:0]  record_size;

    modport source (output valid, output operation, output now_ms, output record_type,
                    output record_size, input ready);
    modport sink (input valid, input operation, input now_ms, input record_type,
                  input record_size, output ready);
endinterface

interface lbrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [11:0] record_offset;
    logic [15:0] time_delta;
    logic        opened_block;
    logic [47:0] block_time;
    logic [31:0] header_generation;
    logic [7:0]  echo_type;
    logic [15:0] write_index;
    logic [11:0] sealed_bytes;
    logic        ring_wrapped;
    logic        last;

    modport source (output valid, output kind, output record_offset, output time_delta,
                    output opened_block, output block_time, output header_generation,
                    output echo_type, output write_index, output sealed_bytes,
                    output ring_wrapped, output last, input ready);
    modport sink (input valid, input kind, input record_offset, input time_delta,
                  input opened_block, input block_time, input header_generation,
                  input echo_type, input write_index, input sealed_bytes,
                  input ring_wrapped, input last, output ready);
endinterface

interface lbrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/lbrp_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbrp_cfg_regs
// Configuration registers and load strobes for the generation and ring state.
// ----------------------------------------------------------------------------
`default_nettype none

module lbrp_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lbrp_cfg_if.sink         i_cfg_ch,
    output lbrp_pkg::t_cfg   o_cfg
);

    logic [11:0] r_block_payload_bytes;
    logic [15:0] r_ring_block_count;
    logic        wr;

    assign i_cfg_ch.ready = 1'b1;
    assign wr = i_cfg_ch.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_payload_bytes <= lbrp_pkg::RESET_BLOCK_PAYLOAD_BYTES;
            r_ring_block_count    <= lbrp_pkg::RESET_RING_BLOCK_COUNT;
        end else if (wr) begin
            if (i_cfg_ch.index == lbrp_pkg::REG_BLOCK_PAYLOAD_BYTES) begin
                r_block_payload_bytes <= i_cfg_ch.data[11:0];
            end
            if (i_cfg_ch.index == lbrp_pkg::REG_RING_BLOCK_COUNT) begin
                r_ring_block_count <= i_cfg_ch.data[15:0];
            end
        end
    end

    always_comb begin
        o_cfg.block_payload_bytes = r_block_payload_bytes;
        o_cfg.ring_block_count    = r_ring_block_count;
        o_cfg.load_generation     = wr && (i_cfg_ch.index == lbrp_pkg::REG_START_GENERATION);
        o_cfg.load_block          = wr && (i_cfg_ch.index == lbrp_pkg::REG_START_BLOCK);
        o_cfg.load_value          = i_cfg_ch.data;
    end

endmodule

`default_nettype wire

// File: design/lbrp_engine.sv
// ----------------------------------------------------------------------------
// lbrp_engine
// Input register, packer state and the single-pass decision for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbrp_engine #(
    parameter int RECORD_HEADER_BYTES = lbrp_pkg::RECORD_HEADER_BYTES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    lbrp_in_if.sink             i_in_ch,
    input  wire lbrp_pkg::t_cfg i_cfg,
    output lbrp_pkg::t_batch    o_batch,
    input  wire logic           i_batch_ready
);

    logic            r_in_valid;
    lbrp_pkg::t_item r_in;

    logic [11:0] r_fill;
    logic [47:0] r_cbt;
    logic [31:0] r_og;
    logic [31:0] r_gc;
    logic [15:0] r_rp;
    logic        r_pend;

    logic [11:0] n_fill;
    logic [47:0] n_cbt;
    logic [31:0] n_og;
    logic [31:0] n_gc;
    logic [15:0] n_rp;
    logic        n_pend;

    logic        accept;
    logic        commit;
    logic [11:0] need;
    logic        too_large;
    logic        empty;
    logic [47:0] t0;
    logic [31:0] og0;
    logic        back;
    logic [47:0] delta;
    logic [12:0] fill_sum;
    logic        fits;
    logic [31:0] gc_next;
    logic [15:0] eff_count;
    logic [15:0] slot;
    logic        wrap;
    logic [15:0] slot_next;
    lbrp_pkg::t_result res0;
    lbrp_pkg::t_result res1;
    lbrp_pkg::t_result seal_res;
    logic        two;

    assign accept         = i_in_ch.valid && i_in_ch.ready;
    assign commit         = r_in_valid && i_batch_ready;
    assign i_in_ch.ready  = !r_in_valid || i_batch_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.operation   <= i_in_ch.operation;
            r_in.now_ms      <= i_in_ch.now_ms;
            r_in.record_type <= i_in_ch.record_type;
            r_in.record_size <= i_in_ch.record_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cbt  <= '0;
            r_og   <= '0;
            r_gc   <= lbrp_pkg::RESET_START_GENERATION;
            r_rp   <= lbrp_pkg::RESET_START_BLOCK;
            r_pend <= 1'b0;
        end else begin
            if (commit) begin
                r_fill <= n_fill;
                r_cbt  <= n_cbt;
                r_og   <= n_og;
                r_pend <= n_pend;
            end
            if (i_cfg.load_generation) begin
                r_gc <= i_cfg.load_value;
            end else if (commit) begin
                r_gc <= n_gc;
            end
            if (i_cfg.load_block) begin
                r_rp <= i_cfg.load_value[15:0];
            end else if (commit) begin
                r_rp <= n_rp;
            end
        end
    end

    assign need      = 12'(r_in.record_size) + 12'(RECORD_HEADER_BYTES);
    assign too_large = need > i_cfg.block_payload_bytes;
    assign empty     = (r_fill == '0);
    assign t0        = empty ? r_in.now_ms : r_cbt;
    assign og0       = empty ? r_gc : r_og;
    assign back      = r_in.now_ms < t0;
    assign delta     = r_in.now_ms - t0;
    assign fill_sum  = {1'b0, r_fill} + {1'b0, need};
    assign fits      = !back && (delta[47:16] == '0) && (delta[15:0] <= lbrp_pkg::MAX_DELTA)
                       && (fill_sum <= {1'b0, i_cfg.block_payload_bytes});
    assign gc_next   = back ? r_gc + 32'd1 : r_gc;

    assign eff_count = (i_cfg.ring_block_count == '0) ? 16'd1 : i_cfg.ring_block_count;
    assign slot      = (r_rp >= eff_count) ? '0 : r_rp;
    assign wrap      = ({1'b0, slot} + 17'd1) >= {1'b0, eff_count};
    assign slot_next = wrap ? '0 : slot + 16'd1;

    always_comb begin
        seal_res                   = '0;
        seal_res.kind              = lbrp_pkg::KIND_SEALED;
        seal_res.block_time        = r_cbt;
        seal_res.header_generation = r_og;
        seal_res.write_index       = slot;
        seal_res.sealed_bytes      = r_fill;
        seal_res.ring_wrapped      = wrap;
    end

    always_comb begin
        n_fill = r_fill;
        n_cbt  = r_cbt;
        n_og   = r_og;
        n_gc   = r_gc;
        n_rp   = r_rp;
        n_pend = r_pend;
        res0   = '0;
        res1   = '0;
        two    = 1'b0;
        res0.kind = lbrp_pkg::KIND_NOTHING;
        unique case (r_in.operation)
            lbrp_pkg::OP_APPEND: begin
                if (too_large) begin
                    res0.kind = lbrp_pkg::KIND_TOO_LARGE;
                end else if (fits) begin
                    res0.kind              = lbrp_pkg::KIND_STORED;
                    res0.record_offset     = r_fill;
                    res0.time_delta        = delta[15:0];
                    res0.opened_block      = empty;
                    res0.block_time        = t0;
                    res0.header_generation = og0;
                    res0.echo_type         = r_in.record_type;
                    n_cbt  = t0;
                    n_og   = og0;
                    n_fill = fill_sum[11:0];
                end else if (r_pend) begin
                    res0.kind = lbrp_pkg::KIND_BUSY;
                    n_gc      = gc_next;
                end else begin
                    res0                   = seal_res;
                    two                    = 1'b1;
                    res1.kind              = lbrp_pkg::KIND_STORED;
                    res1.opened_block      = 1'b1;
                    res1.block_time        = r_in.now_ms;
                    res1.header_generation = gc_next;
                    res1.echo_type         = r_in.record_type;
                    n_gc   = gc_next;
                    n_og   = gc_next;
                    n_cbt  = r_in.now_ms;
                    n_fill = need;
                    n_pend = 1'b1;
                end
            end
            lbrp_pkg::OP_FLUSH: begin
                if (empty) begin
                    res0.kind = lbrp_pkg::KIND_NOTHING;
                end else if (r_pend) begin
                    res0.kind = lbrp_pkg::KIND_BUSY;
                end else begin
                    res0   = seal_res;
                    n_fill = '0;
                    n_pend = 1'b1;
                end
            end
            lbrp_pkg::OP_WRITTEN: begin
                if (r_pend) begin
                    res0.kind         = lbrp_pkg::KIND_WRITE_ACK;
                    res0.write_index  = slot;
                    res0.ring_wrapped = wrap;
                    n_rp   = slot_next;
                    n_pend = 1'b0;
                end
            end
            default: begin
                res0.kind = lbrp_pkg::KIND_NOTHING;
            end
        endcase
        if (two) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    always_comb begin
        o_batch.valid  = r_in_valid;
        o_batch.two    = two;
        o_batch.first  = res0;
        o_batch.second = res1;
    end

endmodule

`default_nettype wire

// File: design/lbrp_result_queue.sv
// ----------------------------------------------------------------------------
// lbrp_result_queue
// Two-entry result queue that takes one or two results per item and hands
// them out one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lbrp_result_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lbrp_pkg::t_batch i_batch,
    output logic                  o_batch_ready,
    lbrp_out_if.source            o_out_ch
);

    lbrp_pkg::t_result r_s0;
    lbrp_pkg::t_result r_s1;
    logic [1:0]        r_cnt;

    lbrp_pkg::t_result n_s0;
    lbrp_pkg::t_result n_s1;
    logic [1:0]        n_cnt;

    logic       pop;
    logic       push;
    logic [1:0] cap;

    assign pop           = (r_cnt != 2'd0) && o_out_ch.ready;
    assign cap           = r_cnt - {1'b0, pop};
    assign o_batch_ready = i_batch.two ? (cap == 2'd0) : (cap != 2'd2);
    assign push          = i_batch.valid && o_batch_ready;

    always_comb begin
        n_s0  = r_s0;
        n_s1  = r_s1;
        n_cnt = cap;
        if (pop) begin
            n_s0 = r_s1;
        end
        if (push) begin
            if (cap == 2'd0) begin
                n_s0 = i_batch.first;
                n_s1 = i_batch.second;
            end else begin
                n_s1 = i_batch.first;
            end
            n_cnt = cap + (i_batch.two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

    assign o_out_ch.valid             = (r_cnt != 2'd0);
    assign o_out_ch.kind              = r_s0.kind;
    assign o_out_ch.record_offset     = r_s0.record_offset;
    assign o_out_ch.time_delta        = r_s0.time_delta;
    assign o_out_ch.opened_block      = r_s0.opened_block;
    assign o_out_ch.block_time        = r_s0.block_time;
    assign o_out_ch.header_generation = r_s0.header_generation;
    assign o_out_ch.echo_type         = r_s0.echo_type;
    assign o_out_ch.write_index       = r_s0.write_index;
    assign o_out_ch.sealed_bytes      = r_s0.sealed_bytes;
    assign o_out_ch.ring_wrapped      = r_s0.ring_wrapped;
    assign o_out_ch.last              = r_s0.last;

endmodule

`default_nettype wire

// File: design/log_block_record_packer.sv
// ----------------------------------------------------------------------------
// log_block_record_packer
// The first result of an item passes the input register and then the result queue
// register before it is offered; a full result queue holds it in the input register.
// Throughput: one item per cycle when it yields one result and o_out_ch is not stalled;
// an append that seals and stores yields two results and needs an empty result queue.
// Reset clears the pipeline and the packer state and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module log_block_record_packer #(
    parameter int RECORD_HEADER_BYTES = lbrp_pkg::RECORD_HEADER_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lbrp_in_if.sink   i_in_ch,
    lbrp_cfg_if.sink  i_cfg_ch,
    lbrp_out_if.source o_out_ch
);

    lbrp_pkg::t_cfg   cfg;
    lbrp_pkg::t_batch batch;
    logic             batch_ready;

    lbrp_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_cfg    (cfg)
    );

    lbrp_engine #(
        .RECORD_HEADER_BYTES (RECORD_HEADER_BYTES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (i_in_ch),
        .i_cfg         (cfg),
        .o_batch       (batch),
        .i_batch_ready (batch_ready)
    );

    lbrp_result_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch       (batch),
        .o_batch_ready (batch_ready),
        .o_out_ch      (o_out_ch)
    );

endmodule

`default_nettype wire
